FILE: hw/rtl/arxbh_pkg.sv
// Package for the add-rotate-xor block hash unit: word type, mixing constants
// and the byte, rotate and tail-padding helpers. No dependencies.

package arxbh_pkg;

  typedef logic [63:0] word_t;

  localparam logic CFG_BYTE_SWAP = 1'b0;

  localparam word_t BLOCK_BYTES = 64'd64;
  localparam word_t CHAIN_LO    = 64'hefcdab8967452301;
  localparam word_t CHAIN_HI    = 64'h1032547698badcfe;

  localparam word_t MIX_ADD [8] = '{
    64'hFFFFFFFFFFFFFFC5, 64'd13166748625691186689, 64'd1573836600196043749,
    64'd1478582680485693857, 64'd1584163446043636637, 64'd1358537349836140151,
    64'd2849285319520710901, 64'd2366157163652459183
  };

  localparam int MIX_ROT [8] = '{17, 19, 23, 29, 31, 37, 41, 53};

  localparam logic [5:0] INIT_OFF [16] = '{
    6'd1, 6'd2, 6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
    6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43
  };

  function automatic word_t bswap(word_t x);
    word_t r;
    for (int b = 0; b < 8; b++) begin
      r[8*(7-b) +: 8] = x[8*b +: 8];
    end
    return r;
  endfunction

  // rotate right by the amount belonging to substep n
  function automatic word_t rot_mix(word_t x, logic [2:0] n);
    word_t r;
    r = x;
    for (int k = 0; k < 8; k++) begin
      if (n == 3'(k)) begin
        r = (x >> MIX_ROT[k]) | (x << (64 - MIX_ROT[k]));
      end
    end
    return r;
  endfunction

  // tail word p: stored bytes below len, pad byte above, length word after
  function automatic word_t tail_word(word_t w, logic [2:0] p, logic [5:0] len);
    word_t      r;
    logic [7:0] pad;
    pad = {2'b10, len};
    for (int b = 0; b < 8; b++) begin
      r[8*b +: 8] = ({p, 3'(b)} < len) ? w[8*b +: 8] : pad;
    end
    if ({1'b0, p} == ({1'b0, len[5:3]} + 4'd1)) begin
      r = {58'd0, len};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/add_rotate_xor_block_hash_unit.sv
// Top level of the add-rotate-xor block hash unit: stream in, stream out, APB register.
// Depends on arxbh_pkg.

// Message words enter one per transfer; in_tuser marks the first word (seed and
// length in tdata are taken then), in_tlast the final word, which yields one
// result transfer. All arithmetic runs through one shared 64-bit add/subtract
// unit, so the rate is set by that unit: a first word also builds the state,
// a word that completes a 64-byte block adds ROUND_COUNT rounds of eight
// mixing substeps (three steps each), and a final word adds ROUND_COUNT tail
// rounds, the fold and the output load. Input is not taken while a word is
// being worked on; a finished hash waits in the output register without
// holding up the next input, but the next result waits until it is taken.

module add_rotate_xor_block_hash_unit #(
  parameter int HASH_BITS   = 128,
  parameter int ROUND_COUNT = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [199:0]  in_tdata,   // seed, message_length, data_word, byte_count
  input  logic          in_tuser,   // first_item
  input  logic          in_tlast,   // last_item
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // hash_word0, hash_word1
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import arxbh_pkg::*;

  localparam int RndW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RndW-1:0] RND_LAST = RndW'(ROUND_COUNT - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BASE   = 3'd1;
  localparam logic [2:0] S_INIT   = 3'd2;
  localparam logic [2:0] S_ABSORB = 3'd3;
  localparam logic [2:0] S_MIX    = 3'd4;
  localparam logic [2:0] S_FOLD   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [1:0] PH_MIX = 2'd0;
  localparam logic [1:0] PH_XOR = 2'd1;
  localparam logic [1:0] PH_SUB = 2'd2;

  logic [2:0]      state_r, state_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic            tail_r, tail_nxt;
  logic [2:0]      pos_r, pos_nxt;
  word_t           rem_r, rem_nxt;
  logic            tfull_r, tfull_nxt;
  logic            swap_r;
  logic            out_valid_r, out_valid_nxt;
  word_t           chain_r, chain_nxt;
  word_t           st_r [16];
  word_t           st_nxt [16];
  word_t           tmp [16];
  word_t           buf_r [8];
  word_t           seed_r, len_r, word_r;
  logic            last_r;
  word_t           out_w0_r, out_w1_r;

  logic            in_acc, cfg_wr, lo, out_ld, buf_we, rem_big;
  logic [2:0]      n, buf_wa;
  logic [5:0]      tlen;
  word_t           buf_wd, d_word, a_val, c_val, rot;
  word_t           add_a, add_b, add_res;
  logic            add_sub;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == CFG_BYTE_SWAP) ? {31'd0, swap_r} : 32'd0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_w1_r, out_w0_r};

  assign n       = cnt_r[2:0];
  assign lo      = rnd_r[0];
  assign rem_big = (rem_r[63:6] != 58'd0);
  assign tlen    = rem_big ? 6'd63 : rem_r[5:0];
  assign d_word  = tail_r ? tail_word(buf_r[n], n, tlen) : buf_r[n];
  assign a_val   = lo ? st_r[0] : st_r[8];
  assign c_val   = (lo && n != 3'd7) ? st_r[1] : st_r[9];

  // shared add/subtract unit
  assign add_res = add_a + (add_b ^ {64{add_sub}}) + {63'd0, add_sub};
  assign rot     = rot_mix(add_res, n);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    rnd_nxt   = rnd_r;
    tail_nxt  = tail_r;
    chain_nxt = chain_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    tfull_nxt = tfull_r;
    st_nxt    = st_r;
    tmp       = st_r;
    buf_we    = 1'b0;
    buf_wa    = pos_r;
    buf_wd    = word_r;
    add_a     = '0;
    add_b     = '0;
    add_sub   = 1'b0;
    out_ld    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tuser ? S_BASE : S_ABSORB;
        end
      end
      S_BASE: begin
        add_a     = seed_r;
        add_b     = len_r;
        chain_nxt = add_res;
        cnt_nxt   = 4'd0;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        add_a = chain_r;
        add_b = {58'd0, INIT_OFF[cnt_r]};
        for (int i = 0; i < 15; i++) begin
          st_nxt[i] = st_r[i+1];
        end
        st_nxt[15] = add_res;
        if (!cnt_r[3]) begin
          buf_we = 1'b1;
          buf_wa = cnt_r[2:0];
          buf_wd = '0;
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          pos_nxt   = 3'd0;
          rem_nxt   = len_r;
          tfull_nxt = 1'b0;
          state_nxt = S_ABSORB;
        end
      end
      S_ABSORB: begin
        rnd_nxt = '0;
        cnt_nxt = 4'd0;
        ph_nxt  = PH_MIX;
        if (rem_big) begin
          buf_we  = 1'b1;
          buf_wd  = swap_r ? bswap(word_r) : word_r;
          pos_nxt = pos_r + 3'd1;
          if (pos_r == 3'd7) begin
            add_a     = rem_r;
            add_b     = BLOCK_BYTES;
            add_sub   = 1'b1;
            rem_nxt   = add_res;
            tfull_nxt = 1'b0;
            tail_nxt  = 1'b0;
            state_nxt = S_MIX;
          end else begin
            tail_nxt  = 1'b1;
            state_nxt = last_r ? S_MIX : S_IDLE;
          end
        end else begin
          if (!tfull_r && ({pos_r, 3'd0} < rem_r[5:0])) begin
            buf_we = 1'b1;
            if (pos_r == 3'd7) begin
              tfull_nxt = 1'b1;
            end else begin
              pos_nxt = pos_r + 3'd1;
            end
          end
          tail_nxt  = 1'b1;
          state_nxt = last_r ? S_MIX : S_IDLE;
        end
      end
      S_MIX: begin
        case (ph_r)
          PH_MIX: begin
            add_a   = a_val ^ d_word;
            add_b   = MIX_ADD[n];
            add_sub = 1'b1;
            if (lo) begin
              st_nxt[0] = rot;
            end else begin
              st_nxt[8] = rot;
            end
            if (n == 3'd0) begin
              chain_nxt = lo ? CHAIN_LO : CHAIN_HI;
            end
            // block words are consumed by the last round, so clear them here
            if (!tail_r && rnd_r == RND_LAST) begin
              buf_we = 1'b1;
              buf_wa = n;
              buf_wd = '0;
            end
            ph_nxt = PH_XOR;
          end
          PH_XOR: begin
            if (lo) begin
              st_nxt[8] = st_r[8] ^ st_r[0];
            end else begin
              st_nxt[0] = st_r[0] ^ st_r[8];
            end
            add_a     = chain_r;
            add_b     = a_val;
            chain_nxt = add_res;
            ph_nxt    = PH_SUB;
          end
          PH_SUB: begin
            add_a   = c_val;
            add_b   = chain_r;
            add_sub = 1'b1;
            if (lo && n != 3'd7) begin
              tmp[1] = add_res;
            end else begin
              tmp[9] = add_res;
            end
            for (int i = 0; i < 8; i++) begin
              st_nxt[i]   = tmp[(i + 1) & 7];
              st_nxt[i+8] = tmp[((i + 1) & 7) + 8];
            end
            ph_nxt  = PH_MIX;
            cnt_nxt = {1'b0, n + 3'd1};
            if (n == 3'd7) begin
              if (rnd_r == RND_LAST) begin
                rnd_nxt = '0;
                if (tail_r) begin
                  cnt_nxt   = 4'd0;
                  state_nxt = S_FOLD;
                end else if (last_r) begin
                  tail_nxt = 1'b1;
                end else begin
                  state_nxt = S_IDLE;
                end
              end else begin
                rnd_nxt = rnd_r + RndW'(1);
              end
            end
          end
          default: ph_nxt = PH_MIX;
        endcase
      end
      S_FOLD: begin
        add_a   = st_r[0];
        add_b   = st_r[8];
        add_sub = 1'b1;
        tmp[0]  = add_res;
        for (int i = 0; i < 8; i++) begin
          st_nxt[i]   = tmp[(i + 1) & 7];
          st_nxt[i+8] = tmp[((i + 1) & 7) + 8];
        end
        cnt_nxt = cnt_r + 4'd1;
        if (n == 3'd7) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_ld | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 4'd0;
      ph_r        <= PH_MIX;
      rnd_r       <= '0;
      tail_r      <= 1'b0;
      pos_r       <= 3'd0;
      rem_r       <= '0;
      tfull_r     <= 1'b0;
      swap_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        st_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ph_r        <= ph_nxt;
      rnd_r       <= rnd_nxt;
      tail_r      <= tail_nxt;
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      tfull_r     <= tfull_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      if (cfg_wr && cfg_paddr[2] == CFG_BYTE_SWAP) begin
        swap_r <= cfg_pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    chain_r <= chain_nxt;
    if (in_acc) begin
      seed_r <= in_tdata[63:0];
      len_r  <= in_tdata[127:64];
      word_r <= in_tdata[191:128];
      last_r <= in_tlast;
    end
    if (out_ld) begin
      out_w0_r <= swap_r ? bswap(st_r[0]) : st_r[0];
      if (HASH_BITS >= 128) begin
        out_w1_r <= swap_r ? bswap(st_r[1]) : st_r[1];
      end else begin
        out_w1_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[buf_wa] <= buf_wd;
    end
  end

`ifndef NO_ASSERTIONS
  a_tail_full_pos: assert property (@(posedge clk) disable iff (!rst_n)
    tfull_r |-> pos_r == 3'd7)
    else $error("tail full flag set away from last slot");

  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ABSORB && state_r != S_INIT) |=> $stable(pos_r))
    else $error("word position moved outside absorb or init");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside output state");

  a_plain_word_absorb: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tuser) |=> state_r == S_ABSORB)
    else $error("plain word did not go to absorb");

  a_fold_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD) |-> tail_r)
    else $error("fold without tail rounds");
`endif

endmodule

FILE: dv/testbench.sv
// Testbench for add_rotate_xor_block_hash_unit: directed and random message streams,
// a scoreboard class predicting every hash and checking each result transfer.
// Depends on arxbh_pkg and the unit's RTL.

module testbench;
  import arxbh_pkg::*;

  localparam int HASH_BITS = 128;
  localparam int ROUNDS    = 3;
  localparam int WATCHDOG  = 20000;
  localparam int SETTLE    = 200;
  localparam int HOLD_OFF  = 800;
  localparam int PHASE_WORDS = 190;
  localparam logic [2:0] SWAP_ADDR = 3'(4 * int'(CFG_BYTE_SWAP));

  typedef word_t block_t [8];

  class hash_scoreboard;
    word_t        h [16];
    block_t       blk;
    logic [2:0]   pos;
    word_t        remaining;
    bit           tail_full;
    bit           swap;
    logic [127:0] pending_hashes [$];
    int           errors;
    int           checked;

    function new();
      foreach (h[n]) h[n] = '0;
      foreach (blk[n]) blk[n] = '0;
      pos = '0;
      remaining = '0;
      tail_full = 0;
      swap = 0;
      errors = 0;
      checked = 0;
    endfunction

    function word_t byte_rev(word_t x);
      word_t r;
      r = {<<8{x}};
      return r;
    endfunction

    function word_t rotr(word_t x, int z);
      return (x >> z) | (x << (64 - z));
    endfunction

    function word_t shown(word_t x);
      return swap ? byte_rev(x) : x;
    endfunction

    // even rounds mix the upper half, odd rounds the lower half
    function void mix_round(block_t d, bit low_side);
      word_t chain;
      if (low_side) begin
        chain = CHAIN_LO;
        for (int n = 0; n < 8; n++) begin
          h[n] = rotr((h[n] ^ d[n]) - MIX_ADD[n], MIX_ROT[n]);
          h[n + 8] ^= h[n];
          chain += h[n];
          h[n + 1] -= chain;
        end
      end else begin
        chain = CHAIN_HI;
        for (int n = 0; n < 8; n++) begin
          h[n + 8] = rotr((h[n + 8] ^ d[n]) - MIX_ADD[n], MIX_ROT[n]);
          h[n] ^= h[n + 8];
          chain += h[n + 8];
          h[((n + 1) % 8) + 8] -= chain;
        end
      end
    endfunction

    function void run_rounds(block_t d);
      for (int r = 0; r < ROUNDS; r++) begin
        mix_round(d, r[0]);
      end
    endfunction

    function void report(string what, word_t want, word_t got);
      errors++;
      if (errors <= 10) begin
        $display("mismatch %s: expected %h got %h", what, want, got);
      end
    endfunction

    function void note_word(bit first, word_t seed, word_t len, word_t word, bit last);
      word_t      base;
      block_t     t;
      logic [5:0] tlen;
      logic [7:0] pad_byte;
      word_t      pad;
      word_t      keep;
      int         nb;
      int         idx;
      if (first) begin
        base = seed + len;
        foreach (h[n]) h[n] = base + word_t'(INIT_OFF[n]);
        foreach (blk[n]) blk[n] = '0;
        pos = '0;
        remaining = len;
        tail_full = 0;
      end
      if (remaining >= 64) begin
        blk[pos] = swap ? byte_rev(word) : word;
        pos = pos + 3'd1;
        if (pos == 3'd0) begin
          run_rounds(blk);
          remaining -= 64;
          foreach (blk[n]) blk[n] = '0;
          tail_full = 0;
        end
      end else if (!tail_full && ((word_t'(pos) << 3) < remaining)) begin
        blk[pos] = word;
        if (pos == 3'd7) begin
          tail_full = 1;
        end else begin
          pos = pos + 3'd1;
        end
      end
      if (!last) return;
      // tail: early last saturates at 63 bytes
      tlen = (remaining >= 64) ? 6'd63 : remaining[5:0];
      pad_byte = 8'h80 + {2'b00, tlen};
      pad = {8{pad_byte}};
      for (int p = 0; p < 8; p++) begin
        nb = int'(tlen) - 8 * p;
        if (nb >= 8) begin
          t[p] = blk[p];
        end else begin
          if (nb < 0) nb = 0;
          keep = ~({64{1'b1}} << (8 * nb));
          t[p] = (blk[p] & keep) | (pad & ~keep);
        end
      end
      // length word falls off the block for a 56..63 byte tail
      idx = int'(tlen) / 8 + 1;
      if (idx < 8) t[idx] = word_t'(tlen);
      run_rounds(t);
      for (int p = 0; p < 8; p++) begin
        h[p] -= h[p + 8];
      end
      pending_hashes.push_back({(HASH_BITS >= 128) ? shown(h[1]) : 64'd0, shown(h[0])});
    endfunction

    function void check_hash(logic [127:0] got);
      logic [127:0] want;
      if (pending_hashes.size() == 0) begin
        report("hash with none pending", 64'bx, got[63:0]);
        return;
      end
      want = pending_hashes.pop_front();
      checked++;
      if (got[63:0] !== want[63:0]) report("hash_word0", want[63:0], got[63:0]);
      if (got[127:64] !== want[127:64]) report("hash_word1", want[127:64], got[127:64]);
    endfunction
  endclass

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [199:0] in_tdata = '0;   // seed, message_length, data_word, byte_count
  logic         in_tuser = 1'b0; // first_item
  logic         in_tlast = 1'b0; // last_item
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // hash_word0, hash_word1
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  hash_scoreboard sb = new;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet = 0;
  int words_sent = 0;
  int messages = 0;

  add_rotate_xor_block_hash_unit #(
    .HASH_BITS(HASH_BITS),
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_word(in_tuser, in_tdata[63:0], in_tdata[127:64], in_tdata[191:128], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        sb.check_hash(out_tdata);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= WATCHDOG) begin
          $display("watchdog: no transfer for %0d cycles", WATCHDOG);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(bit first, word_t seed, word_t len, word_t word,
                           logic [3:0] cnt, bit last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= first;
    in_tlast <= last;
    in_tdata <= {4'd0, cnt, word, len, seed};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_swap(bit v);
    logic [31:0] got;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= SWAP_ADDR;
    cfg_pwdata <= {31'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.swap = v;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (got[0] !== v) sb.report("byte_swap readback", word_t'(v), word_t'(got));
  endtask

  // mostly well-formed messages; the rest truncated, padded, oversized,
  // headless or never terminated
  task automatic send_random_message();
    word_t      seed;
    word_t      len;
    int         kind;
    int         r;
    int         blen;
    int         nwords;
    int         sent;
    logic [3:0] cnt;
    seed = rand64();
    kind = ($urandom_range(99) < 80) ? 0 : $urandom_range(1, 5);
    r = $urandom_range(99);
    if (r < 15) blen = $urandom_range(0, 16);
    else if (r < 75) blen = $urandom_range(17, 140);
    else if (r < 95) blen = $urandom_range(141, 300);
    else blen = $urandom_range(301, 600);
    len = word_t'(blen);
    nwords = (blen == 0) ? 1 : (blen + 7) / 8;
    sent = nwords;
    case (kind)
      1: sent = $urandom_range(1, nwords);
      2: sent = nwords + $urandom_range(1, 3);
      3: begin
        len = rand64();
        if (len < 64) len = len | 64'd64;
        sent = $urandom_range(1, 12);
      end
      4: sent = $urandom_range(1, 4);
      default: ;
    endcase
    messages++;
    for (int i = 0; i < sent; i++) begin
      if (kind == 3) cnt = 4'd8;
      else if (8 * i < blen) cnt = (blen - 8 * i >= 8) ? 4'd8 : 4'(blen - 8 * i);
      else if (blen == 0) cnt = 4'd0;
      else cnt = 4'($urandom_range(0, 8));
      send_item(i == 0 && kind != 4, (i == 0) ? seed : rand64(), (i == 0) ? len : rand64(),
                rand64(), cnt, (i == sent - 1) && kind != 5);
    end
  endtask

  task automatic run_random(int target);
    int start;
    start = words_sent;
    while (words_sent - start < target) send_random_message();
  endtask

  initial begin
    int idle_tab [4];
    int stall_tab [4];
    idle_tab = '{0, 58, 0, 23};
    stall_tab = '{0, 0, 58, 23};
    @(posedge clk);
    @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_swap(1'b0);

    // empty message: pure padding block
    send_item(1, '0, '0, '0, 4'd0, 1);
    messages++;
    // single byte, all-ones seed and word
    send_item(1, '1, 64'd1, '1, 4'd1, 1);
    messages++;
    // one full block, empty tail
    for (int i = 0; i < 8; i++) begin
      send_item(i == 0, 64'h0123456789abcdef, 64'd64, rand64(), 4'd8, i == 7);
    end
    messages++;
    // long tail of 60 bytes: length word dropped
    for (int i = 0; i < 8; i++) begin
      send_item(i == 0, rand64(), 64'd60, rand64(), (i == 7) ? 4'd4 : 4'd8, i == 7);
    end
    messages++;
    // tail words never sent: missing bytes read as zero
    send_item(1, rand64(), 64'd20, '1, 4'd8, 1);
    messages++;
    // early last with all-ones length
    send_item(1, '1, '1, rand64(), 4'd8, 1);
    messages++;
    // words beyond the length are ignored
    for (int i = 0; i < 3; i++) begin
      send_item(i == 0, rand64(), 64'd3, rand64(), (i == 0) ? 4'd3 : 4'd0, i == 2);
    end
    messages++;
    // word with no first item carries on from the current state
    send_item(0, rand64(), rand64(), rand64(), 4'd5, 1);
    messages++;
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_swap(ph[0] ? 1'b0 : 1'b1);
      send_idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      if (ph == 0) hold_left = HOLD_OFF;
      run_random(PHASE_WORDS);
      settle();
    end

    if (sb.pending_hashes.size() != 0) begin
      $display("%0d hashes never delivered", sb.pending_hashes.size());
      sb.errors += sb.pending_hashes.size();
    end
    $display("covered %0d words in %0d messages, %0d hashes compared, %0d mismatches",
             words_sent, messages, sb.checked, sb.errors);
    $display("byte swap off and on, idle and stall mixes, one long output hold-off");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
